>>> sv/ddmp_pkg.sv
// Shared types and constants for the differential-drive move profile unit.
// No dependencies.
package ddmp_pkg;

	localparam int TGT_W      = 31;  // move_target width
	localparam int DIR_W      = 2;   // move_direction width
	localparam int CFG_W      = 31;  // config write data, widest register
	localparam int SPEED_W    = 16;  // Q2.14 speed
	localparam int XW         = 34;  // scale factor: (2*target)*3, 8, 12 or 16
	localparam int DNW        = 36;  // divisor: 25*target, 125 or 1
	localparam int QW         = 15;  // unsaturated speed magnitude bits
	localparam int SAT_SHIFT  = 6;   // 32768/512
	localparam int FRAC_SHIFT = 9;   // 512 scale of the numerator
	localparam int LOWP       = DNW + SAT_SHIFT;
	localparam int NW         = LOWP + FRAC_SHIFT;

	localparam int WINDOW     = 80;  // 2 * 40 count done window
	localparam int AVOID_SPAN = 100; // 2 * 50 count back-off limit
	localparam int CRUISE_DEN = 125;
	localparam int RAMP_MUL   = 25;
	localparam int K_MOVE     = 200;
	localparam int K_AVOID    = 100;
	localparam int X_ROT      = 8;
	localparam int X_LIN      = 12;
	localparam int X_AVOID    = 16;

	typedef enum logic [1:0] {
		MODE_ROTATE = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_AVOID  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE      = 2'd0,
		REG_TARGET    = 2'd1,
		REG_DIRECTION = 2'd2
	} cfg_reg_t;

endpackage

>>> sv/diff_drive_move_profile_unit.sv
// Top level of the differential-drive move profile unit: config registers,
// front end, item queue and scale pipeline. Depends on ddmp_pkg and all ddmp modules.
//
// Usage:
//   Config: write cfg_data to register cfg_index (0 mode, 1 target, 2 direction)
//   at any edge with cfg_we high, only while no item is in flight.
//   Input: an item (left_count, right_count) is taken at each edge with start
//   high; busy is always low, so a new item may follow every cycle.
//   Output: each item gives one result; strobe is high for one cycle with
//   left_speed, right_speed and done_res. The item passes the front 2 stages,
//   queue 1, multiply 2, saturation check 1, 15 divider stages producing one
//   quotient bit each and output register 1 before the strobe.
//   Throughput is one item per cycle; the divider is fully pipelined.
//   Results leave in input order and cannot be held off by the receiver.
//   Reset clears the registers to rotate mode, target 0, direction +1, and
//   drops every item in flight.
module diff_drive_move_profile_unit import ddmp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COUNT_WIDTH-1:0] left_count,
	input  logic [COUNT_WIDTH-1:0] right_count,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   strobe,
	output logic [SPEED_W-1:0]     left_speed,
	output logic [SPEED_W-1:0]     right_speed,
	output logic                   done_res
);

	localparam int BW      = COUNT_WIDTH + 3;
	localparam int FW      = XW + DNW + 2 * BW + 3;
	localparam int LATENCY = 22;

	logic [1:0]       mode_q;
	logic [TGT_W-1:0] target_q;
	logic [DIR_W-1:0] direction_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 2'(MODE_ROTATE);
			target_q    <= '0;
			direction_q <= DIR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:      mode_q      <= cfg_data[1:0];
				REG_TARGET:    target_q    <= cfg_data[TGT_W-1:0];
				REG_DIRECTION: direction_q <= cfg_data[DIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic           f_valid, f_done, f_negl, f_negr;
	logic [XW-1:0]  f_x;
	logic [DNW-1:0] f_den;
	logic [BW-1:0]  f_mbl, f_mbr;

	ddmp_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.left_count (left_count),
		.right_count(right_count),
		.mode       (mode_q),
		.target     (target_q),
		.direction  (direction_q),
		.valid_s2   (f_valid),
		.done_s2    (f_done),
		.x_s2       (f_x),
		.den_s2     (f_den),
		.mbl_s2     (f_mbl),
		.mbr_s2     (f_mbr),
		.negl_s2    (f_negl),
		.negr_s2    (f_negr)
	);

	logic [FW-1:0]  q_din, q_dout;
	logic           q_ne, q_full;
	logic           b_done, b_negl, b_negr;
	logic [XW-1:0]  b_x;
	logic [DNW-1:0] b_den;
	logic [BW-1:0]  b_mbl, b_mbr;

	assign q_din = {f_done, f_negl, f_negr, f_x, f_den, f_mbl, f_mbr};
	assign {b_done, b_negl, b_negr, b_x, b_den, b_mbl, b_mbr} = q_dout;

	// back end never stalls, so the head item leaves every cycle it is present
	ddmp_fifo #(.WIDTH(FW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.din      (q_din),
		.pop      (q_ne),
		.dout     (q_dout),
		.not_empty(q_ne),
		.full     (q_full)
	);

	ddmp_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (q_ne),
		.done       (b_done),
		.x          (b_x),
		.den        (b_den),
		.mbl        (b_mbl),
		.mbr        (b_mbr),
		.negl       (b_negl),
		.negr       (b_negr),
		.strobe     (strobe),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.done_res   (done_res)
	);

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && done_res |-> left_speed == '0 && right_speed == '0)
		else $error("done result with nonzero speed");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_valid && q_full && !q_ne))
		else $error("item queue overflow");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY strobe)
		else $error("result missing at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, LATENCY) || !$past(arst_n, LATENCY))
		else $error("result without an accepted item");

endmodule

>>> sv/ddmp_front.sv
// Front end: classifies an encoder sample by mode and builds the scale operands.
// Depends on ddmp_pkg.
module ddmp_front import ddmp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH-1:0] left_count,
	input  logic [COUNT_WIDTH-1:0] right_count,
	input  logic [1:0]             mode,
	input  logic [TGT_W-1:0]       target,
	input  logic [DIR_W-1:0]       direction,
	output logic                   valid_s2,
	output logic                   done_s2,
	output logic [XW-1:0]          x_s2,
	output logic [DNW-1:0]         den_s2,
	output logic [COUNT_WIDTH+2:0] mbl_s2,
	output logic [COUNT_WIDTH+2:0] mbr_s2,
	output logic                   negl_s2,
	output logic                   negr_s2
);

	localparam int CW = COUNT_WIDTH;
	localparam int SW = CW + 1;
	localparam int BW = CW + 3;
	localparam int EW = ((CW + 1 > 32) ? CW + 1 : 32) + 2;
	localparam int RW = ((CW + 1 > TGT_W) ? CW + 1 : TGT_W) + 3;

	logic signed [SW-1:0] sum, dif, span;
	logic signed [BW-1:0] sum_b, dif_b, dir_b, k, bl, br;
	logic [SW-1:0]        s;

	logic                 valid_s1;
	mode_t                mode_s1;
	logic [SW-1:0]        s_s1;
	logic signed [BW-1:0] bl_s1, br_s1;

	assign sum   = $signed({left_count[CW-1], left_count})
		+ $signed({right_count[CW-1], right_count});
	assign dif   = $signed({right_count[CW-1], right_count})
		- $signed({left_count[CW-1], left_count});
	assign sum_b = BW'(sum);
	assign dif_b = BW'(dif);
	assign dir_b = BW'($signed(direction));
	assign k     = (mode_t'(mode) == MODE_AVOID) ? dir_b * BW'(K_AVOID) : dir_b * BW'(K_MOVE);
	assign span  = (mode_t'(mode) == MODE_ROTATE) ? sum : dif;
	assign s     = span[SW-1] ? SW'(-span) : SW'(span);

	always_comb begin
		unique case (mode_t'(mode))
			MODE_ROTATE: begin
				bl = k + dif_b;
				br = k - dif_b;
			end
			MODE_LINEAR: begin
				bl = -k - sum_b;
				br = k - sum_b;
			end
			MODE_AVOID: begin
				bl = k - sum_b;
				br = -k - sum_b;
			end
			default: begin
				bl = '0;
				br = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_t'(mode);
		s_s1    <= s;
		bl_s1   <= bl;
		br_s1   <= br;
	end

	// second stage: window, ramp test and operand select
	logic signed [EW-1:0] e, win_p, win_n;
	logic [RW-1:0]        s5, t6;
	logic [31:0]          a;
	logic [XW-1:0]        xr;
	logic [DNW-1:0]       den25;
	logic                 near, ramp, rot;
	logic                 done_c;
	logic [XW-1:0]        x_c;
	logic [DNW-1:0]       den_c;

	assign e     = $signed({{(EW-TGT_W-1){1'b0}}, target, 1'b0}) - $signed({{(EW-SW){1'b0}}, s_s1});
	assign win_p = EW'(WINDOW);
	assign win_n = -win_p;
	assign near  = (e <= win_p) && (e >= win_n);
	assign s5    = (RW'(s_s1) << 2) + RW'(s_s1);
	assign t6    = (RW'(target) << 2) + (RW'(target) << 1);
	assign ramp  = s5 >= t6;
	assign rot   = (mode_s1 == MODE_ROTATE);
	assign a     = e[EW-1] ? 32'd0 : e[31:0];
	assign xr    = XW'({a, 1'b0}) + (rot ? XW'(0) : XW'(a));
	assign den25 = DNW'(target) * DNW'(RAMP_MUL);

	always_comb begin
		done_c = 1'b1;
		x_c    = '0;
		den_c  = DNW'(1);
		unique case (mode_s1) inside
			MODE_ROTATE, MODE_LINEAR: begin
				if (!near) begin
					done_c = 1'b0;
					if (ramp) begin
						if (target != '0) begin
							x_c   = xr;
							den_c = den25;
						end
					end else begin
						x_c   = rot ? XW'(X_ROT) : XW'(X_LIN);
						den_c = DNW'(CRUISE_DEN);
					end
				end
			end
			MODE_AVOID: begin
				if (s_s1 > SW'(AVOID_SPAN)) begin
					done_c = 1'b0;
					x_c    = XW'(X_AVOID);
					den_c  = DNW'(CRUISE_DEN);
				end
			end
			default: begin
				done_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		done_s2 <= done_c;
		x_s2    <= x_c;
		den_s2  <= den_c;
		mbl_s2  <= bl_s1[BW-1] ? BW'(-bl_s1) : BW'(bl_s1);
		mbr_s2  <= br_s1[BW-1] ? BW'(-br_s1) : BW'(br_s1);
		negl_s2 <= bl_s1[BW-1];
		negr_s2 <= br_s1[BW-1];
	end

endmodule

>>> sv/ddmp_fifo.sv
// Two-entry item queue between the front end and the scale pipeline.
// Depends on ddmp_pkg (imported for house consistency of widths only).
module ddmp_fifo import ddmp_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty,
	output logic             full
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/ddmp_back.sv
// Back end: per wheel, x*|b|*512/den with saturation to Q2.14.
// Split multiplier, then a pipelined restoring divider. Depends on ddmp_pkg.
module ddmp_back import ddmp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic                   done,
	input  logic [XW-1:0]          x,
	input  logic [DNW-1:0]         den,
	input  logic [COUNT_WIDTH+2:0] mbl,
	input  logic [COUNT_WIDTH+2:0] mbr,
	input  logic                   negl,
	input  logic                   negr,
	output logic                   strobe,
	output logic [SPEED_W-1:0]     left_speed,
	output logic [SPEED_W-1:0]     right_speed,
	output logic                   done_res
);

	localparam int BW = COUNT_WIDTH + 3;
	localparam int XL = XW / 2;
	localparam int XH = XW - XL;
	localparam int ML = (BW + 1) / 2;
	localparam int MH = BW - ML;
	localparam int PW = XW + BW;

	logic [BW-1:0] mb [2];
	logic          ng [2];

	assign mb[0] = mbl;
	assign mb[1] = mbr;
	assign ng[0] = negl;
	assign ng[1] = negr;

	// stage 1: partial products
	logic              valid_s1, done_s1;
	logic [DNW-1:0]    den_s1;
	logic              neg_s1 [2];
	logic [XL+ML-1:0]  pp0_s1 [2];
	logic [XL+MH-1:0]  pp1_s1 [2];
	logic [XH+ML-1:0]  pp2_s1 [2];
	logic [XH+MH-1:0]  pp3_s1 [2];

	// stage 2: full product
	logic              valid_s2, done_s2;
	logic [DNW-1:0]    den_s2;
	logic              neg_s2 [2];
	logic [PW-1:0]     p_s2 [2];

	// divider stages, index 0 is the saturation check stage
	logic              vld_sd  [QW+1];
	logic              done_sd [QW+1];
	logic [DNW-1:0]    den_sd  [QW+1];
	logic              neg_sd  [QW+1][2];
	logic              sat_sd  [QW+1][2];
	logic [NW-1:0]     rem_sd  [QW+1][2];
	logic [QW-1:0]     q_sd    [QW+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			vld_sd[0] <= 1'b0;
		end else begin
			valid_s1  <= valid;
			valid_s2  <= valid_s1;
			vld_sd[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		done_s1    <= done;
		den_s1     <= den;
		done_s2    <= done_s1;
		den_s2     <= den_s1;
		done_sd[0] <= done_s2;
		den_sd[0]  <= den_s2;
		for (int ln = 0; ln < 2; ln++) begin
			neg_s1[ln] <= ng[ln];
			pp0_s1[ln] <= (XL+ML)'(x[XL-1:0]) * (XL+ML)'(mb[ln][ML-1:0]);
			pp1_s1[ln] <= (XL+MH)'(x[XL-1:0]) * (XL+MH)'(mb[ln][BW-1:ML]);
			pp2_s1[ln] <= (XH+ML)'(x[XW-1:XL]) * (XH+ML)'(mb[ln][ML-1:0]);
			pp3_s1[ln] <= (XH+MH)'(x[XW-1:XL]) * (XH+MH)'(mb[ln][BW-1:ML]);
			neg_s2[ln] <= neg_s1[ln];
			p_s2[ln]   <= PW'(pp0_s1[ln]) + (PW'(pp1_s1[ln]) << ML)
				+ (PW'(pp2_s1[ln]) << XL) + (PW'(pp3_s1[ln]) << (XL + ML));
			neg_sd[0][ln] <= neg_s2[ln];
			// a product at or above 64*den overflows Q2.14; otherwise it fits LOWP bits
			sat_sd[0][ln] <= p_s2[ln] >= PW'({den_s2, {SAT_SHIFT{1'b0}}});
			rem_sd[0][ln] <= {p_s2[ln][LOWP-1:0], {FRAC_SHIFT{1'b0}}};
			q_sd[0][ln]   <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int SH = QW - 1 - j;
		logic [NW-1:0] dsh;
		logic [NW:0]   trial [2];

		assign dsh = NW'(den_sd[j]) << SH;
		assign trial[0] = {1'b0, rem_sd[j][0]} - {1'b0, dsh};
		assign trial[1] = {1'b0, rem_sd[j][1]} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j+1] <= 1'b0;
			end else begin
				vld_sd[j+1] <= vld_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			done_sd[j+1] <= done_sd[j];
			den_sd[j+1]  <= den_sd[j];
			for (int ln = 0; ln < 2; ln++) begin
				neg_sd[j+1][ln] <= neg_sd[j][ln];
				sat_sd[j+1][ln] <= sat_sd[j][ln];
				rem_sd[j+1][ln] <= trial[ln][NW] ? rem_sd[j][ln] : trial[ln][NW-1:0];
				q_sd[j+1][ln]   <= {q_sd[j][ln][QW-2:0], ~trial[ln][NW]};
			end
		end
	end

	logic [SPEED_W-1:0] spd [2];

	always_comb begin
		for (int ln = 0; ln < 2; ln++) begin
			if (sat_sd[QW][ln]) begin
				spd[ln] = neg_sd[QW][ln] ? 16'h8000 : 16'h7fff;
			end else if (neg_sd[QW][ln]) begin
				spd[ln] = SPEED_W'(-{1'b0, q_sd[QW][ln]});
			end else begin
				spd[ln] = SPEED_W'({1'b0, q_sd[QW][ln]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_sd[QW];
		end
	end

	always_ff @(posedge clk) begin
		left_speed  <= spd[0];
		right_speed <= spd[1];
		done_res    <= done_sd[QW];
	end

endmodule
